// ----- sv/dth_pkg.sv -----
`timescale 1ns / 1ps
package dth_pkg;
    localparam int SLOT_W = 5;
    localparam int SLOT_SPACE = 32;
    localparam int EXP_W = 25;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_SWEEP  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_CLOSE     = 3'd3,
        KIND_DONE      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] now_ms;
        logic [23:0] timeout_ms;
        logic [15:0] request_handle;
        logic [4:0]  target_slot;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [15:0] handle;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [EXP_W-1:0]  expiry;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    // heap order: earlier expiry first, ties by smaller slot
    function automatic logic ahead(entry_t a, entry_t b);
        if (a.expiry != b.expiry)
            return a.expiry < b.expiry;
        return a.slot < b.slot;
    endfunction
endpackage

// ----- sv/deadline_timer_heap.sv -----
`timescale 1ns / 1ps
// Deadline timer queue held as a binary min-heap in one synchronous memory with a registered
// read port. Add writes the new entry at the end and climbs up to 5 heap levels toward the root,
// a full queue or a cancel answers without touching the heap, and a sweep checks the head, pops
// it if it has expired or been cancelled, moves the last entry to the root and sifts it down,
// and repeats until the head is live or the heap is empty. Results come out with a one-cycle
// strobe and cannot be held off; busy stays high from the accepting edge until the transaction
// has finished and its last result has been shown.
module deadline_timer_heap #(
    parameter int CAPACITY = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dth_pkg::req_t     request,
    output logic              result_valid,
    output dth_pkg::rsp_t     result
);
    localparam int USABLE = (CAPACITY < dth_pkg::SLOT_SPACE) ? CAPACITY : dth_pkg::SLOT_SPACE;
    localparam int SW = dth_pkg::SLOT_W;
    localparam int CW = SW + 1;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_UPRD   = 11'b00000000010,
        ST_UPCMP  = 11'b00000000100,
        ST_HEAD   = 11'b00000001000,
        ST_HEADCK = 11'b00000010000,
        ST_LASTRD = 11'b00000100000,
        ST_DNRDL  = 11'b00001000000,
        ST_DNRDR  = 11'b00010000000,
        ST_DNCMP  = 11'b00100000000,
        ST_OUT    = 11'b01000000000,
        ST_DNWR   = 11'b10000000000
    } state_t;

    dth_pkg::entry_t heap_mem [dth_pkg::SLOT_SPACE];
    logic [15:0]     handle_mem [dth_pkg::SLOT_SPACE];

    logic [USABLE-1:0] in_use_reg, in_use_next;
    logic [USABLE-1:0] cancel_reg, cancel_next;
    logic [CW-1:0]     count_reg, count_next;
    state_t            state_reg, state_next;
    dth_pkg::req_t     req_reg, req_next;
    logic [SW-1:0]     pos_reg, pos_next;
    dth_pkg::entry_t   cur_reg, cur_next;
    dth_pkg::entry_t   lch_reg, lch_next;
    logic              outv_reg, outv_next;
    dth_pkg::rsp_t     out_reg, out_next;

    // memory port
    logic            rd_en, wr_en;
    logic [SW-1:0]   rd_addr, wr_addr;
    dth_pkg::entry_t wr_data, rd_data;
    logic            hw_en;
    logic [SW-1:0]   hw_addr, hr_addr;
    logic [15:0]     hr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= heap_mem[rd_addr];
        if (hw_en)
            handle_mem[hw_addr] <= req_reg.request_handle;
        hr_data <= handle_mem[hr_addr];
    end

    // free slot search
    logic          free_found;
    logic [SW-1:0] free_slot;
    always_comb
    begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = USABLE - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    logic [SW-1:0] parent;
    logic [CW:0]   lidx, ridx;
    logic [SW-1:0] head_s;
    logic          head_cancel;
    assign parent = (pos_reg - SW'(1)) >> 1;
    assign lidx = {pos_reg, 1'b1} + (CW+1)'(0);
    assign ridx = lidx + (CW+1)'(1);
    assign head_s = rd_data.slot;
    assign head_cancel = (32'(head_s) < USABLE) ? cancel_reg[head_s[SW-1:0]] : 1'b0;

    always_comb
    begin
        state_next = state_reg;
        in_use_next = in_use_reg;
        cancel_next = cancel_reg;
        count_next = count_reg;
        req_next = req_reg;
        pos_next = pos_reg;
        cur_next = cur_reg;
        lch_next = lch_reg;
        outv_next = 1'b0;
        out_next = out_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = cur_reg;
        hw_en = 1'b0;
        hw_addr = cur_reg.slot;
        hr_addr = head_s;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !busy)
                begin
                    req_next = request;
                    unique case (dth_pkg::cmd_t'(request.command))
                        dth_pkg::CMD_ADD:
                        begin
                            outv_next = 1'b1;
                            out_next = '0;
                            out_next.last = 1'b1;
                            if (!free_found)
                                out_next.kind = dth_pkg::KIND_FULL;
                            else
                            begin
                                out_next.kind = dth_pkg::KIND_ADDED;
                                out_next.slot = free_slot;
                                in_use_next[free_slot] = 1'b1;
                                cancel_next[free_slot] = 1'b0;
                                cur_next.expiry = dth_pkg::EXP_W'(request.now_ms)
                                                + dth_pkg::EXP_W'(request.timeout_ms);
                                cur_next.slot = free_slot;
                                pos_next = count_reg[SW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = ST_UPRD;
                            end
                        end
                        dth_pkg::CMD_CANCEL:
                        begin
                            if (32'(request.target_slot) < USABLE)
                                if (in_use_reg[request.target_slot])
                                    cancel_next[request.target_slot] = 1'b1;
                            outv_next = 1'b1;
                            out_next = '0;
                            out_next.kind = dth_pkg::KIND_CANCELLED;
                            out_next.slot = request.target_slot;
                            out_next.last = 1'b1;
                            state_next = ST_OUT;
                        end
                        dth_pkg::CMD_SWEEP:
                        begin
                            state_next = ST_HEAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPRD:
            begin
                // write current at pos, then consider parent
                hw_en = (pos_reg == count_reg[SW-1:0] - SW'(1)) ? 1'b1 : 1'b0;
                wr_en = 1'b1;
                wr_addr = pos_reg;
                if (pos_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = parent;
                    state_next = ST_UPCMP;
                end
            end
            ST_UPCMP:
            begin
                if (dth_pkg::ahead(cur_reg, rd_data))
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = rd_data;
                    pos_next = parent;
                    state_next = ST_UPRD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_HEAD:
            begin
                if (count_reg == '0)
                begin
                    outv_next = 1'b1;
                    out_next = '0;
                    out_next.kind = dth_pkg::KIND_DONE;
                    out_next.last = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = '0;
                    state_next = ST_HEADCK;
                end
            end
            ST_HEADCK:
            begin
                if (head_cancel || (dth_pkg::EXP_W'(req_reg.now_ms) >= rd_data.expiry))
                begin
                    in_use_next[head_s] = 1'b0;
                    cancel_next[head_s] = 1'b0;
                    lch_next.slot = head_s;
                    lch_next.expiry = {dth_pkg::EXP_W{head_cancel}};
                    count_next = count_reg - CW'(1);
                    rd_en = 1'b1;
                    rd_addr = SW'(count_reg - CW'(1));
                    state_next = ST_LASTRD;
                end
                else
                begin
                    outv_next = 1'b1;
                    out_next = '0;
                    out_next.kind = dth_pkg::KIND_DONE;
                    out_next.last = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_LASTRD:
            begin
                // hr_data holds the popped handle this cycle
                hr_addr = lch_reg.slot;
                if (lch_reg.expiry[0] == 1'b0)
                begin
                    outv_next = 1'b1;
                    out_next = '0;
                    out_next.kind = dth_pkg::KIND_CLOSE;
                    out_next.slot = lch_reg.slot;
                    out_next.handle = hr_data;
                end
                cur_next = rd_data;
                pos_next = '0;
                state_next = ST_DNRDL;
            end
            ST_DNRDL:
            begin
                if (lidx < (CW+1)'(count_reg))
                begin
                    rd_en = 1'b1;
                    rd_addr = SW'(lidx);
                    state_next = ST_DNRDR;
                end
                else
                    state_next = ST_DNWR;
            end
            ST_DNRDR:
            begin
                lch_next = rd_data;
                if (ridx < (CW+1)'(count_reg))
                begin
                    rd_en = 1'b1;
                    rd_addr = SW'(ridx);
                end
                state_next = ST_DNCMP;
            end
            ST_DNCMP:
            begin
                priority if ((ridx < (CW+1)'(count_reg)) && dth_pkg::ahead(rd_data, lch_reg)
                             && dth_pkg::ahead(rd_data, cur_reg))
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = rd_data;
                    pos_next = SW'(ridx);
                    state_next = ST_DNRDL;
                end
                else if (dth_pkg::ahead(lch_reg, cur_reg))
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = lch_reg;
                    pos_next = SW'(lidx);
                    state_next = ST_DNRDL;
                end
                else
                    state_next = ST_DNWR;
            end
            ST_DNWR:
            begin
                if (count_reg != '0)
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                end
                state_next = ST_HEAD;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            in_use_reg <= '0;
            cancel_reg <= '0;
            count_reg <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_use_reg <= in_use_next;
            cancel_reg <= cancel_next;
            count_reg <= count_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        lch_reg <= lch_next;
        out_reg <= out_next;
    end

    assign busy = (state_reg != ST_IDLE) || outv_reg;
    assign result_valid = outv_reg;
    assign result = out_reg;

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) 32'(count_reg) <= USABLE;
    endproperty
    assert property (p_count_bound) else $error("heap count above capacity");

    property p_count_matches;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_IDLE) |-> ($countones(in_use_reg) == 32'(count_reg));
    endproperty
    assert property (p_count_matches) else $error("heap count differs from slots in use");

    property p_cancel_live;
        @(posedge clk) disable iff (!rst_n) (cancel_reg & ~in_use_reg) == '0;
    endproperty
    assert property (p_cancel_live) else $error("cancel mark on free slot");
endmodule
